FILE: src/m3f_pkg.sv
`timescale 1ns / 1ps
package m3f_pkg;

	// field and register widths
	localparam int PIX_W = 8;
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 12;
	localparam int CFG_W = HEIGHT_W;
	localparam int CFG_IDX_W = 1;

	// largest values the width and height registers can hold
	localparam int WIDTH_REG_MAX = (1 << WIDTH_W) - 1;
	localparam int ROW_MAX = (1 << HEIGHT_W) - 1;

	// line store depth default
	localparam int MAX_WIDTH_DEF = 1024;

	// register reset values and lower clamps
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd320;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd240;
	localparam logic [WIDTH_W-1:0] WIDTH_MIN = 11'd3;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 12'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t pixel_in;
		logic flush;
	} pix_in_t;

	typedef struct packed {
		pix_t pixel_out;
		logic end_of_frame;
	} pix_out_t;

	// output position status for the item being accepted
	typedef struct packed {
		logic interior;
		logic last;
	} pos_status_t;

endpackage

FILE: src/m3f_stream_if.sv
`timescale 1ns / 1ps
interface m3f_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/m3f_line_mem.sv
`timescale 1ns / 1ps
module m3f_line_mem import m3f_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int DATA_W = 2 * PIX_W
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [DATA_W-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/m3f_pos_track.sv
`timescale 1ns / 1ps
module m3f_pos_track import m3f_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr,
	input logic [WIDTH_W-1:0] width,
	input logic [HEIGHT_W-1:0] height,
	input logic step,
	output logic busy,
	output pos_status_t status
);

	localparam int EFF_W = (MAX_WIDTH < WIDTH_REG_MAX) ? MAX_WIDTH : WIDTH_REG_MAX;
	localparam int POS_W = $clog2(EFF_W * ROW_MAX);
	localparam int ROW_W = POS_W - 1;
	localparam int CNT_W = $clog2(POS_W + 1);
	localparam int W_RST = (int'(WIDTH_RESET) > MAX_WIDTH) ? MAX_WIDTH : int'(WIDTH_RESET);
	localparam logic [POS_W-1:0] WH_RST = POS_W'(W_RST * int'(HEIGHT_RESET) - 1);

	logic [POS_W-1:0] pos_q;
	logic [ROW_W-1:0] row_q;
	logic [WIDTH_W-1:0] col_q;
	logic [POS_W-1:0] wh_m1_q;
	logic start_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic [POS_W-1:0] dvd_q;
	logic [POS_W-1:0] quo_q;
	logic [WIDTH_W-1:0] rem_q;
	logic [WIDTH_W:0] trial;
	logic [WIDTH_W-1:0] rem_nxt;
	logic qbit;

	assign busy = start_q || (div_cnt_q != '0);

	// window position checks for the next output pixel
	always_comb begin
		status.interior = (row_q != '0) && (32'(row_q) + 32'd2 <= 32'(height))
			&& (col_q != '0) && (32'(col_q) + 32'd2 <= 32'(width));
		status.last = pos_q >= wh_m1_q;
	end

	// one restoring divide step per cycle
	always_comb begin
		trial = {rem_q, dvd_q[POS_W-1]};
		if (trial >= {1'b0, width}) begin
			rem_nxt = WIDTH_W'(trial - {1'b0, width});
			qbit = 1'b1;
		end else begin
			rem_nxt = trial[WIDTH_W-1:0];
			qbit = 1'b0;
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (start_q) begin
			dvd_q <= pos_q;
			quo_q <= '0;
			rem_q <= '0;
		end else if (div_cnt_q != '0) begin
			dvd_q <= {dvd_q[POS_W-2:0], 1'b0};
			quo_q <= {quo_q[POS_W-2:0], qbit};
			rem_q <= rem_nxt;
		end
	end

	// position counters, frame size product and divide control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			row_q <= '0;
			col_q <= '0;
			wh_m1_q <= WH_RST;
			start_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			wh_m1_q <= POS_W'(32'(width) * 32'(height) - 32'd1);
			start_q <= cfg_wr;
			if (start_q) begin
				div_cnt_q <= CNT_W'(POS_W);
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == CNT_W'(1)) begin
					row_q <= {quo_q[ROW_W-2:0], qbit};
					col_q <= rem_nxt;
				end
			end else if (step) begin
				if (status.last) begin
					pos_q <= '0;
					row_q <= '0;
					col_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
					if (32'(col_q) + 32'd1 >= 32'(width)) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	a_no_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !step)
		else $error("position advanced while recomputing row and column");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> col_q < width)
		else $error("output column outside the row");

	a_pos_split: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> 40'(pos_q) == 40'(row_q) * 40'(width) + 40'(col_q))
		else $error("row and column disagree with output position");

endmodule

FILE: src/m3f_median.sv
`timescale 1ns / 1ps
module m3f_median import m3f_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input pix_t window [9],
	input logic interior,
	input logic last,
	output logic out_valid,
	output pix_out_t out_data
);

	function automatic pix_t pmin(pix_t a, pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t pmax(pix_t a, pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t pmed(pix_t a, pix_t b, pix_t c);
		return pmax(pmin(a, b), pmin(pmax(a, b), c));
	endfunction

	pix_t lo_s3 [3];
	pix_t mid_s3 [3];
	pix_t hi_s3 [3];
	pix_t center_s3;
	logic interior_s3;
	logic last_s3;
	logic valid_s3;

	pix_t lo_max_s4;
	pix_t mid_med_s4;
	pix_t hi_min_s4;
	pix_t center_s4;
	logic interior_s4;
	logic last_s4;
	logic valid_s4;

	logic out_valid_q;
	pix_out_t out_data_q;
	pix_t med;

	// sort each window row
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				lo_s3[r] <= pmin(pmin(window[r*3], window[r*3+1]), window[r*3+2]);
				mid_s3[r] <= pmed(window[r*3], window[r*3+1], window[r*3+2]);
				hi_s3[r] <= pmax(pmax(window[r*3], window[r*3+1]), window[r*3+2]);
			end
			center_s3 <= window[4];
			interior_s3 <= interior;
			last_s3 <= last;
		end
	end

	// largest low, middle middle, smallest high
	always_ff @(posedge clk) begin
		if (en) begin
			lo_max_s4 <= pmax(pmax(lo_s3[0], lo_s3[1]), lo_s3[2]);
			mid_med_s4 <= pmed(mid_s3[0], mid_s3[1], mid_s3[2]);
			hi_min_s4 <= pmin(pmin(hi_s3[0], hi_s3[1]), hi_s3[2]);
			center_s4 <= center_s3;
			interior_s4 <= interior_s3;
			last_s4 <= last_s3;
		end
	end

	// final median, border pixels pass through
	assign med = pmed(lo_max_s4, mid_med_s4, hi_min_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.pixel_out <= interior_s4 ? med : center_s4;
			out_data_q.end_of_frame <= last_s4;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

FILE: src/median_3x3_filter_unit.sv
`timescale 1ns / 1ps
// Streaming 3x3 median filter for 8-bit grayscale frames.
// pixels: one pixel per transaction in raster order; flush transactions after
//   the last pixel of a frame push out its tail (width + 1 of them per frame).
// results: one filtered pixel per transaction in raster order; end_of_frame
//   marks the last pixel of the frame. Output pixel p leaves with the
//   transaction caused by input item p + width + 1; border rows and columns
//   pass through, interior pixels get the median of their 3x3 neighborhood.
// Configuration: cfg_we/cfg_index/cfg_wdata write image_width (index 0) and
//   image_height (index 1); the user must write only while the block is idle, which the block does not enforce.
// Throughput is one pixel per cycle unless results stalls or the divider
//   is busy. An accepted pixel reaches the output register through line
//   store read, window shift, then a three-stage median network.
// After a configuration write the block takes no pixel while the output row
//   and column are rebuilt by a serial divider from the output position.
// Reset clears window, counters and sets width 320, height 240; the line
//   stores are not cleared, so the first two rows of a frame fill them.
// When results stalls, the output register and every stage hold and
//   pixels.ready drops in the same cycle.
module median_3x3_filter_unit import m3f_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_wdata,
	m3f_stream_if.sink pixels,
	m3f_stream_if.source results
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	typedef struct packed {
		pix_t row2;
		pix_t row1;
	} line_word_t;

	logic [WIDTH_W-1:0] width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [WIDTH_W-1:0] w_c;
	logic [HEIGHT_W-1:0] h_c;

	logic [COL_W-1:0] col_q;
	logic [HEIGHT_W-1:0] row_q;

	logic adv;
	logic busy;
	logic in_fire;
	logic started;
	logic step;
	pix_t pix_acc;
	pos_status_t status;

	logic valid_s1;
	logic started_s1;
	pix_t pix_s1;
	logic [COL_W-1:0] idx_s1;
	logic interior_s1;
	logic last_s1;
	logic fwd_s1;
	line_word_t fwd_data_s1;

	logic valid_s2;
	logic interior_s2;
	logic last_s2;

	line_word_t mem_rdata;
	line_word_t line_rd;
	line_word_t line_wr;
	logic mem_we;
	pix_t window_q [9];

	logic med_valid;
	pix_out_t med_data;

	// clamp the configured size
	always_comb begin
		w_c = width_q;
		if (width_q < WIDTH_MIN) begin
			w_c = WIDTH_MIN;
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_c = WIDTH_W'(MAX_WIDTH);
		end
		h_c = (height_q < HEIGHT_MIN) ? HEIGHT_MIN : height_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_wdata[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake: everything moves unless the output register is stuck; input also waits while busy
	assign adv = !results.valid || results.ready;
	assign pixels.ready = adv && !busy;
	assign in_fire = pixels.valid && pixels.ready;

	// accept-side decode
	always_comb begin
		pix_acc = (pixels.data.flush || row_q >= h_c) ? '0 : pixels.data.pixel_in;
		started = (row_q >= HEIGHT_W'(2)) || (row_q == HEIGHT_W'(1) && col_q != '0);
		step = in_fire && started;
	end

	m3f_pos_track #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_we),
		.width(w_c),
		.height(h_c),
		.step(step),
		.busy(busy),
		.status(status)
	);

	// input column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (step && status.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (32'(col_q) + 32'd1 >= 32'(w_c)) begin
				col_q <= '0;
				if (row_q != '1) begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stage 1 payload, with forwarding of a write to the entry just read
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1 <= pix_acc;
			idx_s1 <= col_q;
			started_s1 <= started;
			interior_s1 <= status.interior;
			last_s1 <= status.last;
			fwd_s1 <= valid_s1 && (idx_s1 == col_q);
			fwd_data_s1 <= line_wr;
		end
	end

	// line stores: row above and row two above, one word per column
	m3f_line_mem #(
		.DEPTH(MAX_WIDTH),
		.DATA_W($bits(line_word_t))
	) u_line_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(idx_s1),
		.wdata(line_wr),
		.re(in_fire),
		.raddr(col_q),
		.rdata(mem_rdata)
	);

	always_comb begin
		line_rd = fwd_s1 ? fwd_data_s1 : mem_rdata;
		line_wr.row2 = line_rd.row1;
		line_wr.row1 = pix_s1;
		mem_we = valid_s1 && adv;
	end

	// window shift: new column enters on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '{default: '0};
		end else if (valid_s1 && adv) begin
			for (int r = 0; r < 3; r++) begin
				window_q[r*3] <= window_q[r*3+1];
				window_q[r*3+1] <= window_q[r*3+2];
			end
			window_q[2] <= line_rd.row2;
			window_q[5] <= line_rd.row1;
			window_q[8] <= pix_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			interior_s2 <= interior_s1;
			last_s2 <= last_s1;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_fire;
			valid_s2 <= valid_s1 && started_s1;
		end
	end

	m3f_median u_median (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(valid_s2),
		.window(window_q),
		.interior(interior_s2),
		.last(last_s2),
		.out_valid(med_valid),
		.out_data(med_data)
	);

	assign results.valid = med_valid;
	assign results.data = med_data;

	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !pixels.ready)
		else $error("pixel taken right after a configuration write");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import m3f_pkg::*;

	localparam int MAX_W = MAX_WIDTH_DEF;
	localparam int POS_W = 22;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int STALL_AT = 24;
	localparam int STALL_CYCLES = 400;
	localparam int RANDOM_ITEMS = 150;
	localparam int WIDE_ITEMS = 1080;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	m3f_stream_if #(.payload_t(pix_in_t)) pixels ();
	m3f_stream_if #(.payload_t(pix_out_t)) results ();

	median_3x3_filter_unit #(.MAX_WIDTH(MAX_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pixels(pixels),
		.results(results)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state: register copies, line stores, window and counters
	logic [WIDTH_W-1:0] width_reg = WIDTH_RESET;
	logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
	pix_t above_row [MAX_W];
	pix_t two_above_row [MAX_W];
	pix_t win [9];
	int unsigned in_col = 0;
	int unsigned in_row = 0;
	int unsigned out_pos = 0;

	pix_in_t pending_pixels [$];
	pix_out_t expected_pixels [$];

	int send_gap_max = 10;
	int take_gap_max = 10;
	int send_gap;
	int take_gap;
	int hold_off;
	int results_seen;
	int quiet_cycles = 0;
	int errors = 0;
	int random_pushed = 0;
	pix_out_t want;

	// effective frame size after clamping
	function automatic int unsigned active_width();
		if (width_reg < WIDTH_MIN)
			return WIDTH_MIN;
		if (width_reg > MAX_W)
			return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned active_height();
		return (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
	endfunction

	// advance the filter by one accepted pixel, queue the pixel it emits
	task automatic filter_step(input pix_in_t item);
		int unsigned w, h, idx, r, c, k, j;
		pix_t px, above, above2, t;
		pix_t srt [9];
		logic started;
		pix_out_t res;
		w = active_width();
		h = active_height();
		px = item.flush ? '0 : item.pixel_in;
		if (in_row >= h)
			px = '0;
		idx = (in_col < MAX_W) ? in_col : MAX_W - 1;
		started = in_row >= 2 || (in_row == 1 && in_col >= 1);
		above = above_row[idx];
		above2 = two_above_row[idx];

		// shift window left, new column enters on the right
		for (k = 0; k < 3; k++) begin
			win[k * 3] = win[k * 3 + 1];
			win[k * 3 + 1] = win[k * 3 + 2];
		end
		win[2] = above2;
		win[5] = above;
		win[8] = px;
		two_above_row[idx] = above;
		above_row[idx] = px;

		// input column and row, row saturates
		if (in_col + 1 >= w) begin
			in_col = 0;
			if (in_row < ROW_MAX)
				in_row++;
		end else begin
			in_col++;
		end
		if (!started)
			return;

		// output pixel: median inside, pass-through on the border
		r = out_pos / w;
		c = out_pos % w;
		if (r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w) begin
			srt = win;
			for (k = 1; k < 9; k++) begin
				t = srt[k];
				j = k;
				while (j > 0 && srt[j - 1] > t) begin
					srt[j] = srt[j - 1];
					j--;
				end
				srt[j] = t;
			end
			res.pixel_out = srt[4];
		end else begin
			res.pixel_out = win[4];
		end
		res.end_of_frame = out_pos >= w * h - 1;
		if (res.end_of_frame) begin
			in_col = 0;
			in_row = 0;
			out_pos = 0;
		end else begin
			out_pos = (out_pos + 1) % (1 << POS_W);
		end
		expected_pixels.push_back(res);
	endtask

	// pixel driver: random gap before each transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels.valid <= 1'b0;
			pixels.data <= '0;
			send_gap = 0;
		end else begin
			if (pixels.valid && pixels.ready)
				filter_step(pixels.data);
			if (!pixels.valid || pixels.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					pixels.valid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					pixels.data <= pending_pixels.pop_front();
					pixels.valid <= 1'b1;
					send_gap = $urandom_range(0, send_gap_max);
				end else begin
					pixels.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare with oldest expected pixel, random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			take_gap = 0;
			hold_off = 0;
			results_seen = 0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none actual %0d/%0b", $time,
						results.data.pixel_out, results.data.end_of_frame);
				end else begin
					want = expected_pixels.pop_front();
					if (results.data.pixel_out !== want.pixel_out) begin
						errors++;
						$display("%0t: pixel_out expected %0d actual %0d", $time,
							want.pixel_out, results.data.pixel_out);
					end
					if (results.data.end_of_frame !== want.end_of_frame) begin
						errors++;
						$display("%0t: end_of_frame expected %0b actual %0b", $time,
							want.end_of_frame, results.data.end_of_frame);
					end
				end
				results_seen++;
				// one long hold-off so the pipeline fills and stalls its input
				if (results_seen == STALL_AT)
					hold_off = STALL_CYCLES;
				take_gap = $urandom_range(0, take_gap_max);
			end else if (hold_off > 0) begin
				hold_off--;
			end else if (take_gap > 0) begin
				take_gap--;
			end
			results.ready <= (hold_off == 0 && take_gap == 0);
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pixels.valid && pixels.ready) || (results.valid && results.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("median_3x3_filter_unit regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_item(input int unsigned value, input logic fl);
		pix_in_t item;
		item.pixel_in = value[PIX_W-1:0];
		item.flush = fl;
		pending_pixels.push_back(item);
	endtask

	// wait until every pixel is taken and every result checked, then let the pipe empty
	task automatic settle();
		while (pending_pixels.size() != 0 || pixels.valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write both registers, spare top bit of the width write is random
	task automatic set_size(input int unsigned w, input int unsigned h);
		logic spare;
		spare = 1'($urandom_range(0, 1));
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_wdata <= {spare, w[WIDTH_W-1:0]};
		width_reg = w[WIDTH_W-1:0];
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_wdata <= h[HEIGHT_W-1:0];
		height_reg = h[HEIGHT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// one frame: pixels then tail, cut off after limit items if limit is set; noise flips the flush mark
	task automatic push_frame(input int noise_pct, input int limit);
		int unsigned w, h, n, i;
		logic odd;
		w = active_width();
		h = active_height();
		n = w * h + w + 1;
		if (limit > 0 && limit < n)
			n = limit;
		for (i = 0; i < n; i++) begin
			odd = $urandom_range(0, 99) < noise_pct;
			push_item($urandom_range(0, 255), (i < w * h) ? odd : !odd);
		end
		random_pushed += n;
	endtask

	// finish a broken frame with flush transactions
	task automatic close_frame();
		while (in_row != 0 || in_col != 0 || out_pos != 0) begin
			push_item($urandom_range(0, 255), 1'b1);
			settle();
			@(negedge clk);
		end
	endtask

	// stimulus
	initial begin
		int unsigned w, h;
		int kind;
		pixels.valid = 1'b0;
		pixels.data = '0;
		results.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// smallest frame: extremes, flush before frame end, pixel after frame end
		set_size(3, 3);
		push_item(0, 1'b0);
		push_item(255, 1'b0);
		push_item(0, 1'b0);
		push_item(255, 1'b0);
		push_item(128, 1'b0);
		push_item(0, 1'b0);
		push_item(255, 1'b0);
		push_item(255, 1'b1);
		push_item(255, 1'b0);
		push_item(0, 1'b1);
		push_item(255, 1'b0);
		push_item(0, 1'b1);
		push_item(0, 1'b1);
		settle();

		// registers below their minimum act as 3x3
		set_size(0, 0);
		for (int i = 0; i < 9; i++)
			push_item((i == 4) ? 0 : 255, 1'b0);
		for (int i = 0; i < 4; i++)
			push_item(255, 1'b0);
		settle();

		// start of the widest frame, width above the line store clamps;
		// no idling, long stall
		send_gap_max = 0;
		take_gap_max = 0;
		set_size(WIDTH_REG_MAX, 3);
		push_frame(0, WIDE_ITEMS);
		settle();

		// size changes in the middle of a frame, output position overtaken
		send_gap_max = 10;
		take_gap_max = 10;
		set_size(8, 6);
		push_frame(10, 40);
		settle();
		set_size(4, 3);
		push_frame(0, 30);
		settle();
		set_size(11, 5);
		push_frame(10, 20);
		settle();
		set_size(9, 4);
		close_frame();

		// random frames, some broken off and resized midway
		random_pushed = 0;
		while (random_pushed < RANDOM_ITEMS) begin
			settle();
			send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			h = $urandom_range(0, 8);
			set_size(w, h);
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				push_frame(10, $urandom_range(1, 30));
			end else begin
				close_frame();
				push_frame((kind < 3) ? 15 : 0, 0);
			end
		end
		settle();

		if (errors == 0) begin
			$display("median_3x3_filter_unit regression: pass");
		end else begin
			$display("median_3x3_filter_unit regression: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/m3f_pkg.sv
src/m3f_stream_if.sv
src/m3f_line_mem.sv
src/m3f_pos_track.sv
src/m3f_median.sv
src/median_3x3_filter_unit.sv
bench/testbench.sv
